FILE: sv/escc_pkg.sv
package escc_pkg;

  localparam int unsigned BASE_YEAR_DEFAULT = 2000;
  localparam int unsigned STAGES = 6;

  localparam int unsigned DAY_SECS  = 86400;
  localparam int unsigned HOUR_SECS = 3600;
  localparam int unsigned MIN_SECS  = 60;
  localparam int unsigned TOD_MAX   = 31 * HOUR_SECS + 63 * MIN_SECS + 63;

  localparam int unsigned DAYS_4Y   = 1461;
  localparam int unsigned DAYS_400Y = 146097;
  localparam int unsigned DAYS_5M   = 153;
  localparam int unsigned DAYS_400Y_QTR = DAYS_400Y / 4;
  localparam int unsigned YEARS_CENTURY = 100;

  // reciprocal constants, exact over the operand widths used
  localparam logic [31:0] RECIP_100 = 32'h51EB851F;
  localparam int unsigned RECIP_100_SHIFT = 37;
  localparam logic [25:0] RECIP_675 = 26'd50903317;
  localparam int unsigned RECIP_675_SHIFT = 35;
  localparam int unsigned DAY_SECS_LOG2_PART = 7;
  localparam logic [17:0] RECIP_3600 = 18'd149131;
  localparam int unsigned RECIP_3600_SHIFT = 29;
  localparam logic [12:0] RECIP_60 = 13'd4370;
  localparam int unsigned RECIP_60_SHIFT = 18;
  localparam logic [18:0] RECIP_1461 = 19'd367469;
  localparam int unsigned RECIP_1461_SHIFT = 29;
  localparam logic [11:0] RECIP_153 = 12'd3427;
  localparam int unsigned RECIP_153_SHIFT = 19;
  localparam logic [11:0] RECIP_5 = 12'd3277;
  localparam int unsigned RECIP_5_SHIFT = 14;

  typedef struct packed {
    logic [11:0] cal_year;
    logic [3:0]  cal_month;
    logic [4:0]  cal_day;
    logic [4:0]  cal_hour;
    logic [5:0]  cal_minute;
    logic [5:0]  cal_second;
    logic [31:0] epoch_count;
  } in_item_t;

  typedef struct packed {
    logic [31:0] total_seconds;
    logic [16:0] day_seconds;
    logic [11:0] out_year;
    logic [3:0]  out_month;
    logic [4:0]  out_day;
    logic [4:0]  out_hour;
    logic [5:0]  out_minute;
    logic [5:0]  out_second;
  } out_item_t;

  // days before month slot m of a march-based year: (m*153+2)/5
  function automatic logic [8:0] month_offset(logic [3:0] m);
    logic [10:0] x;
    logic [22:0] p;
    x = 11'(m) * 11'(DAYS_5M) + 11'd2;
    p = 23'(x) * 23'(RECIP_5);
    return 9'(p >> RECIP_5_SHIFT);
  endfunction

endpackage

FILE: sv/escc_if.sv
interface escc_in_if;
  logic                valid;
  logic                ready;
  escc_pkg::in_item_t  data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface escc_out_if;
  logic                valid;
  logic                ready;
  escc_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: sv/epoch_seconds_calendar_convert_core.sv
// epoch seconds / gregorian calendar converter
// cal_in (sink): one transaction carries a calendar date and time plus an
//   epoch second count; taken when valid and ready are both high
// cal_out (source): one transaction per input, in order, holding the epoch
//   seconds and seconds of day of the calendar fields, and the calendar
//   fields of the epoch count (years start on march 1 internally)
// path: each transaction is registered through stages 1 to 6 before cal_out.valid
// throughput: one transaction per cycle while cal_out.ready is high;
//   the pipeline has six register stages
// stall: every stage advances when it is empty or the stage after it
//   advances, so bubbles close up and cal_in.ready drops only when all
//   six stages hold data and cal_out.ready is low
// reset: rst (synchronous) clears all stage valid bits; nothing else is
//   reset, so the block is ready in the cycle after reset
// BASE_YEAR gives the epoch (march 1 of that year), a multiple of 400
module epoch_seconds_calendar_convert_core #(
  parameter int unsigned BASE_YEAR = escc_pkg::BASE_YEAR_DEFAULT
) (
  input logic        clk,
  input logic        rst,
  escc_in_if.sink    cal_in,
  escc_out_if.source cal_out
);

  typedef struct packed {
    logic [31:0] y;
    logic [3:0]  m;
    logic [4:0]  dy;
    logic [16:0] tod;
    logic [15:0] days;
    logic [16:0] ec_lo;
  } st1_t;

  typedef struct packed {
    logic [31:0] d4;
    logic [25:0] c;
    logic [8:0]  moff;
    logic [4:0]  dy;
    logic [16:0] tod;
    logic [16:0] rem;
    logic        q400;
    logic [15:0] sday;
  } st2_t;

  typedef struct packed {
    logic [31:0] dacc;
    logic [16:0] tod;
    logic [16:0] rem;
    logic [4:0]  hour;
    logic        q400;
    logic [15:0] sday;
    logic [6:0]  q2;
  } st3_t;

  typedef struct packed {
    logic [31:0] total;
    logic [16:0] tod;
    logic [11:0] r2;
    logic [4:0]  hour;
    logic [8:0]  s2;
    logic [11:0] yr;
  } st4_t;

  typedef struct packed {
    logic [31:0] total;
    logic [16:0] tod;
    logic [11:0] r2;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [8:0]  s2;
    logic [3:0]  q3;
    logic [11:0] yr;
  } st5_t;

  logic [escc_pkg::STAGES-1:0] v;
  logic [escc_pkg::STAGES:0]   adv;

  st1_t                st1, st1_next;
  st2_t                st2, st2_next;
  st3_t                st3, st3_next;
  st4_t                st4, st4_next;
  st5_t                st5, st5_next;
  escc_pkg::out_item_t st6, st6_next;

  logic        borrow;
  logic [50:0] days_prod;
  logic [31:0] y1461;
  logic [63:0] c_prod;
  logic [16:0] days_lo;
  logic [17:0] x400;
  logic [27:0] c3;
  logic [34:0] hour_prod;
  logic [17:0] x4y;
  logic [36:0] q2_prod;
  logic [17:0] q2_days;
  logic [24:0] min_prod;
  logic [10:0] x5m;
  logic [22:0] q3_prod;
  logic [8:0]  offs6;
  logic [3:0]  mo6;

  // stall chain
  always_comb begin
    adv[escc_pkg::STAGES] = cal_out.ready;
    for (int k = escc_pkg::STAGES - 1; k >= 0; k--) begin
      adv[k] = !v[k] || adv[k+1];
    end
  end

  assign cal_in.ready  = adv[0];
  assign cal_out.valid = v[escc_pkg::STAGES-1];
  assign cal_out.data  = st6;

  // stage 1: march-based year and month, time of day, day count of epoch
  always_comb begin
    borrow = cal_in.data.cal_month < 4'd3;
    st1_next.y = 32'(cal_in.data.cal_year) - 32'(BASE_YEAR) - 32'(borrow);
    st1_next.m = borrow ? cal_in.data.cal_month + 4'd9 : cal_in.data.cal_month - 4'd3;
    st1_next.dy = cal_in.data.cal_day;
    st1_next.tod = 17'(cal_in.data.cal_hour) * 17'(escc_pkg::HOUR_SECS)
                 + 17'(cal_in.data.cal_minute) * 17'(escc_pkg::MIN_SECS)
                 + 17'(cal_in.data.cal_second);
    days_prod = 51'(cal_in.data.epoch_count >> escc_pkg::DAY_SECS_LOG2_PART)
              * 51'(escc_pkg::RECIP_675);
    st1_next.days = 16'(days_prod >> escc_pkg::RECIP_675_SHIFT);
    st1_next.ec_lo = cal_in.data.epoch_count[16:0];
  end

  // stage 2: four-year days, centuries, month offset, seconds of day, 400-year cycle
  always_comb begin
    y1461 = st1.y * 32'(escc_pkg::DAYS_4Y);
    st2_next.d4 = y1461 >> 2;
    c_prod = 64'(st1.y) * 64'(escc_pkg::RECIP_100);
    st2_next.c = 26'(c_prod >> escc_pkg::RECIP_100_SHIFT);
    st2_next.moff = escc_pkg::month_offset(st1.m);
    st2_next.dy = st1.dy;
    st2_next.tod = st1.tod;
    days_lo = 17'(st1.days) * 17'(escc_pkg::DAY_SECS);
    st2_next.rem = st1.ec_lo - days_lo;
    x400 = {st1.days, 2'b11};
    st2_next.q400 = x400 >= 18'(escc_pkg::DAYS_400Y);
    st2_next.sday = st2_next.q400 ? st1.days - 16'(escc_pkg::DAYS_400Y_QTR) : st1.days;
  end

  // stage 3: day count of calendar input, hour, four-year cycles
  always_comb begin
    c3 = 28'(st2.c) * 28'd3 + 28'd3;
    st3_next.dacc = st2.d4 - 32'(c3 >> 2) + 32'(st2.moff) + 32'(st2.dy) - 32'd1;
    st3_next.tod = st2.tod;
    st3_next.rem = st2.rem;
    hour_prod = 35'(st2.rem) * 35'(escc_pkg::RECIP_3600);
    st3_next.hour = 5'(hour_prod >> escc_pkg::RECIP_3600_SHIFT);
    st3_next.q400 = st2.q400;
    st3_next.sday = st2.sday;
    x4y = {st2.sday, 2'b11};
    q2_prod = 37'(x4y) * 37'(escc_pkg::RECIP_1461);
    st3_next.q2 = 7'(q2_prod >> escc_pkg::RECIP_1461_SHIFT);
  end

  // stage 4: total seconds, seconds within the hour, day of year, year
  always_comb begin
    st4_next.total = st3.dacc * 32'(escc_pkg::DAY_SECS) + 32'(st3.tod);
    st4_next.tod = st3.tod;
    st4_next.r2 = 12'(st3.rem - 17'(st3.hour) * 17'(escc_pkg::HOUR_SECS));
    st4_next.hour = st3.hour;
    q2_days = 18'(st3.q2) * 18'(escc_pkg::DAYS_4Y);
    st4_next.s2 = 9'(18'(st3.sday) - (q2_days >> 2));
    st4_next.yr = 12'(BASE_YEAR) + (st3.q400 ? 12'(escc_pkg::YEARS_CENTURY) : 12'd0)
                + 12'(st3.q2);
  end

  // stage 5: minute, month slot
  always_comb begin
    st5_next.total = st4.total;
    st5_next.tod = st4.tod;
    st5_next.r2 = st4.r2;
    st5_next.hour = st4.hour;
    min_prod = 25'(st4.r2) * 25'(escc_pkg::RECIP_60);
    st5_next.minute = 6'(min_prod >> escc_pkg::RECIP_60_SHIFT);
    st5_next.s2 = st4.s2;
    x5m = 11'(st4.s2) * 11'd5 + 11'd2;
    q3_prod = 23'(x5m) * 23'(escc_pkg::RECIP_153);
    st5_next.q3 = 4'(q3_prod >> escc_pkg::RECIP_153_SHIFT);
    st5_next.yr = st4.yr;
  end

  // stage 6: second, day of month, january/february wrap into next year
  always_comb begin
    st6_next.total_seconds = st5.total;
    st6_next.day_seconds = st5.tod;
    st6_next.out_hour = st5.hour;
    st6_next.out_minute = st5.minute;
    st6_next.out_second = 6'(st5.r2 - 12'(st5.minute) * 12'(escc_pkg::MIN_SECS));
    offs6 = escc_pkg::month_offset(st5.q3);
    st6_next.out_day = 5'(st5.s2 - offs6 + 9'd1);
    mo6 = st5.q3 + 4'd3;
    if (mo6 > 4'd12) begin
      st6_next.out_month = mo6 - 4'd12;
      st6_next.out_year = st5.yr + 12'd1;
    end else begin
      st6_next.out_month = mo6;
      st6_next.out_year = st5.yr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (adv[0]) v[0] <= cal_in.valid;
      for (int k = 1; k < escc_pkg::STAGES; k++) begin
        if (adv[k]) v[k] <= v[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) st1 <= st1_next;
    if (adv[1]) st2 <= st2_next;
    if (adv[2]) st3 <= st3_next;
    if (adv[3]) st4 <= st4_next;
    if (adv[4]) st5 <= st5_next;
    if (adv[5]) st6 <= st6_next;
  end

  a_full_when_blocked: assert property (@(posedge clk) disable iff (rst)
    !cal_in.ready |-> (&v))
    else $error("input blocked while a stage is empty");

  a_month_range: assert property (@(posedge clk) disable iff (rst)
    cal_out.valid |-> (st6.out_month >= 4'd1 && st6.out_month <= 4'd12))
    else $error("month out of range");

  a_day_range: assert property (@(posedge clk) disable iff (rst)
    cal_out.valid |-> (st6.out_day >= 5'd1 && st6.out_day <= 5'd31))
    else $error("day out of range");

  a_time_range: assert property (@(posedge clk) disable iff (rst)
    cal_out.valid |-> (st6.out_hour < 5'd24 && st6.out_minute < 6'd60
                       && st6.out_second < 6'd60))
    else $error("time of day out of range");

  a_tod_range: assert property (@(posedge clk) disable iff (rst)
    cal_out.valid |-> (st6.day_seconds <= 17'(escc_pkg::TOD_MAX)))
    else $error("seconds of day out of range");

endmodule

FILE: tb/sv/tb_top.sv
module tb_top;

  localparam bit [31:0] REF_BASE_YEAR = escc_pkg::BASE_YEAR_DEFAULT;
  localparam bit [31:0] QUAD_DAYS     = 1461;
  localparam bit [31:0] QUADCEN_DAYS  = 146097;
  localparam bit [31:0] FIVEMON_DAYS  = 153;
  localparam int        HOLD_CYCLES   = 120;

  class calendar_scoreboard;
    escc_pkg::out_item_t expected_results[$];
    int unsigned         mismatches;
    int unsigned         results_seen;

    static function escc_pkg::out_item_t predict_calendar(escc_pkg::in_item_t t);
      bit [31:0] y, m, d, c, s, q, yr, mo, hh, mm, ss;
      escc_pkg::out_item_t r;
      // calendar fields to epoch seconds, march-based year, 32-bit wrap
      y = 32'(t.cal_year) - REF_BASE_YEAR;
      m = 32'(t.cal_month);
      if (m < 3) begin
        m = m + 12;
        y = y - 1;
      end
      m = m - 3;
      d = (y * QUAD_DAYS) / 4;
      c = y / 100;
      d = d - (c * 3 + 3) / 4;
      d = d + (m * FIVEMON_DAYS + 2) / 5;
      d = d + (32'(t.cal_day) - 1);
      d = d * 24 + 32'(t.cal_hour);
      d = d * 60 + 32'(t.cal_minute);
      d = d * 60 + 32'(t.cal_second);
      r.total_seconds = d;
      r.day_seconds = 17'((32'(t.cal_hour) * 60 + 32'(t.cal_minute)) * 60
                          + 32'(t.cal_second));
      // epoch seconds to calendar fields
      s  = t.epoch_count;
      ss = s % 60;
      s  = s / 60;
      mm = s % 60;
      s  = s / 60;
      hh = s % 24;
      s  = s / 24;
      q  = (s * 4 + 3) / QUADCEN_DAYS;
      yr = q * 100 + REF_BASE_YEAR;
      s  = s - (q * QUADCEN_DAYS) / 4;
      q  = (s * 4 + 3) / QUAD_DAYS;
      yr = yr + q;
      s  = s - (q * QUAD_DAYS) / 4;
      q  = (s * 5 + 2) / FIVEMON_DAYS;
      mo = q + 3;
      s  = s - (q * FIVEMON_DAYS + 2) / 5;
      if (mo > 12) begin
        mo = mo - 12;
        yr = yr + 1;
      end
      r.out_year   = yr[11:0];
      r.out_month  = mo[3:0];
      r.out_day    = 5'(s + 1);
      r.out_hour   = hh[4:0];
      r.out_minute = mm[5:0];
      r.out_second = ss[5:0];
      return r;
    endfunction

    function void note_request(escc_pkg::in_item_t t);
      expected_results.push_back(predict_calendar(t));
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    function void report_field(string name, logic [31:0] want, logic [31:0] got);
      $display("%0t mismatch on %s: expected %0d actual %0d", $time, name, want, got);
      mismatches++;
    endfunction

    function void check_result(escc_pkg::out_item_t got);
      escc_pkg::out_item_t want;
      results_seen++;
      if (expected_results.size() == 0) begin
        $display("%0t result transaction with nothing expected: actual %p", $time, got);
        mismatches++;
        return;
      end
      want = expected_results.pop_front();
      if (got.total_seconds !== want.total_seconds)
        report_field("total_seconds", want.total_seconds, got.total_seconds);
      if (got.day_seconds !== want.day_seconds)
        report_field("day_seconds", want.day_seconds, got.day_seconds);
      if (got.out_year !== want.out_year)
        report_field("out_year", want.out_year, got.out_year);
      if (got.out_month !== want.out_month)
        report_field("out_month", want.out_month, got.out_month);
      if (got.out_day !== want.out_day)
        report_field("out_day", want.out_day, got.out_day);
      if (got.out_hour !== want.out_hour)
        report_field("out_hour", want.out_hour, got.out_hour);
      if (got.out_minute !== want.out_minute)
        report_field("out_minute", want.out_minute, got.out_minute);
      if (got.out_second !== want.out_second)
        report_field("out_second", want.out_second, got.out_second);
    endfunction
  endclass

  logic clk;
  logic rst;

  escc_in_if  cal_in ();
  escc_out_if cal_out ();

  epoch_seconds_calendar_convert_core uut (
    .clk     (clk),
    .rst     (rst),
    .cal_in  (cal_in),
    .cal_out (cal_out)
  );

  calendar_scoreboard sb = new();

  int tx_idle_pct;
  int rx_idle_pct;
  int hold_tag;
  int hold_len;
  int n_sent;
  int n_directed;
  int n_round_trip;
  int n_raw;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("timeout with %0d results outstanding", sb.pending());
    $display("Verification failed");
    $finish;
  end

  // transaction monitor on both channels
  always @(posedge clk) begin
    if (!rst && cal_in.valid && cal_in.ready)
      sb.note_request(cal_in.data);
    if (!rst && cal_out.valid && cal_out.ready)
      sb.check_result(cal_out.data);
  end

  // output side back-pressure, with a counted hold-off on request
  initial begin
    int hold_seen;
    int hold_left;
    hold_seen = 0;
    hold_left = 0;
    cal_out.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_tag != hold_seen) begin
        hold_seen = hold_tag;
        hold_left = hold_len;
      end
      if (hold_left > 0) begin
        hold_left--;
        cal_out.ready <= 1'b0;
      end else begin
        cal_out.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  function automatic escc_pkg::in_item_t mk(int unsigned y, int unsigned mo, int unsigned d,
                                            int unsigned h, int unsigned mi, int unsigned s,
                                            bit [31:0] ec);
    escc_pkg::in_item_t t;
    t.cal_year    = 12'(y);
    t.cal_month   = 4'(mo);
    t.cal_day     = 5'(d);
    t.cal_hour    = 5'(h);
    t.cal_minute  = 6'(mi);
    t.cal_second  = 6'(s);
    t.epoch_count = ec;
    return t;
  endfunction

  // epoch count taken from the date itself so the reverse path sees real dates
  function automatic escc_pkg::in_item_t round_trip(escc_pkg::in_item_t t);
    t.epoch_count = calendar_scoreboard::predict_calendar(t).total_seconds;
    return t;
  endfunction

  function automatic escc_pkg::in_item_t random_date(int unsigned lo_year,
                                                     int unsigned hi_year);
    return mk($urandom_range(hi_year, lo_year), $urandom_range(12, 1),
              $urandom_range(31, 1), $urandom_range(23), $urandom_range(59),
              $urandom_range(59), $urandom);
  endfunction

  task automatic send_item(input escc_pkg::in_item_t t);
    while ($urandom_range(99) < tx_idle_pct) begin
      cal_in.valid <= 1'b0;
      @(posedge clk);
    end
    cal_in.valid <= 1'b1;
    cal_in.data  <= t;
    @(posedge clk);
    while (!cal_in.ready) @(posedge clk);
    n_sent++;
  endtask

  task automatic drain();
    cal_in.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic send_random();
    escc_pkg::in_item_t t;
    int unsigned centuries [4] = '{1900, 2000, 2100, 2400};
    case ($urandom_range(9)) inside
      [0:2]: t = random_date(0, 4095);
      [3:5]: begin
        t = round_trip(random_date(2000, 2135));
        n_round_trip++;
      end
      [6:7]: begin
        t = mk($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        n_raw++;
      end
      8: begin
        t = mk($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
               $urandom_range(1) ? $urandom_range(200000)
                                 : 32'hFFFF_FFFF - $urandom_range(200000));
        n_raw++;
      end
      default: begin
        // around the leap day and the march year boundary
        t = mk(centuries[$urandom_range(3)] + $urandom_range(8), $urandom_range(3, 1),
               $urandom_range(31), $urandom_range(23), $urandom_range(59),
               $urandom_range(59), 0);
        t = round_trip(t);
        n_round_trip++;
      end
    endcase
    send_item(t);
  endtask

  task automatic send_directed();
    send_item(mk(0, 0, 0, 0, 0, 0, 0));
    send_item(mk(4095, 15, 31, 31, 63, 63, 32'hFFFF_FFFF));
    send_item(round_trip(mk(2000, 3, 1, 0, 0, 0, 0)));
    send_item(round_trip(mk(2000, 2, 29, 23, 59, 59, 0)));
    send_item(mk(2000, 1, 1, 0, 0, 0, 59));
    send_item(mk(2050, 13, 5, 1, 2, 3, 86399));
    send_item(mk(2050, 14, 20, 4, 5, 6, 86400));
    send_item(mk(2001, 0, 10, 7, 8, 9, 3600));
    send_item(round_trip(mk(2004, 3, 0, 0, 0, 0, 0)));
    send_item(round_trip(mk(2004, 2, 29, 12, 30, 45, 0)));
    send_item(round_trip(mk(2100, 2, 28, 23, 59, 59, 0)));
    send_item(round_trip(mk(2100, 3, 1, 0, 0, 0, 0)));
    send_item(round_trip(mk(2400, 2, 29, 6, 0, 0, 0)));
    send_item(round_trip(mk(1999, 12, 31, 23, 59, 59, 0)));
    send_item(round_trip(mk(2136, 2, 7, 6, 28, 15, 0)));
    send_item(mk(1600, 12, 31, 23, 59, 59, 32'h8000_0000));
    send_item(mk(2399, 6, 15, 31, 63, 63, 32'h7FFF_FFFF));
    send_item(round_trip(mk(2001, 3, 1, 0, 0, 0, 0)));
    send_item(round_trip(mk(2003, 12, 31, 23, 59, 59, 0)));
    send_item(mk(2020, 12, 31, 23, 59, 59, 32'h0001_5180));
    n_directed = n_sent;
  endtask

  initial begin
    rst           = 1'b1;
    cal_in.valid  = 1'b0;
    cal_in.data   = '0;
    tx_idle_pct   = 26;
    rx_idle_pct   = 84;
    hold_tag      = 0;
    hold_len      = 0;
    n_sent        = 0;
    n_directed    = 0;
    n_round_trip  = 0;
    n_raw         = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    send_directed();
    repeat (640) send_random();
    drain();

    tx_idle_pct = 84;
    rx_idle_pct = 26;
    repeat (640) send_random();
    drain();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    repeat (320) send_random();
    // long output hold-off while input keeps coming, pipeline must fill and stall
    hold_len = HOLD_CYCLES;
    hold_tag = hold_tag + 1;
    repeat (360) send_random();
    drain();
    repeat (2 * escc_pkg::STAGES) @(posedge clk);

    $display("covered %0d transactions: %0d directed, %0d round-trip dates, %0d raw patterns",
             n_sent, n_directed, n_round_trip, n_raw);
    $display("%0d results checked under three stall profiles and a %0d-cycle hold-off",
             sb.results_seen, HOLD_CYCLES);
    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
